// ----- rtl/imusbc_pkg.sv -----
package imusbc_pkg;

  // Raw six-axis sample plus the armed flag, as one input beat.
  typedef struct packed {
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic               armed;
  } in_t;

  // Bias-corrected sample, as one result beat.
  typedef struct packed {
    logic signed [15:0] gyro_x_corr;
    logic signed [15:0] gyro_y_corr;
    logic signed [15:0] gyro_z_corr;
    logic signed [15:0] accel_x_corr;
    logic signed [15:0] accel_y_corr;
    logic signed [15:0] accel_z_corr;
    logic               calibrated;
  } out_t;

  // A sample after the front end has classified it.
  typedef struct packed {
    in_t  smp;
    logic still;
  } cls_t;

  // Stillness thresholds handed to the front end.
  typedef struct packed {
    logic [15:0] gyro_limit;
    logic [31:0] sq_low;
    logic [31:0] sq_high;
  } thr_t;

  // Back-end status seen at the top level.
  typedef struct packed {
    logic latched;
    logic dividing;
  } bk_stat_t;

  typedef enum logic [1:0] {
    REG_GYRO_LIMIT = 2'd0,
    REG_SQ_LOW     = 2'd1,
    REG_SQ_HIGH    = 2'd2,
    REG_TOTAL      = 2'd3
  } reg_idx_t;

  localparam int          AXES       = 6;
  localparam int          OFF_W      = 17;
  localparam int          CFG_W      = 32;
  localparam logic [15:0] GYRO_LIMIT_RST = 16'd82;
  localparam logic [31:0] SQ_LOW_RST     = 32'd242269225;
  localparam logic [31:0] SQ_HIGH_RST    = 32'd295943209;
  localparam logic [15:0] TOTAL_RST      = 16'd500;
  localparam logic signed [OFF_W-1:0] ONE_G_LSB = 17'sd16384;

  // Magnitude of a 16-bit two's complement value; -32768 gives 32768.
  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    abs16 = v[15] ? (~v + 16'd1) : v;
  endfunction

endpackage

// ----- rtl/imusbc_fifo.sv -----
module imusbc_fifo #(
  parameter int W  = 8,
  parameter int AW = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int DEPTH = 2 ** AW;

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [AW:0]   cnt;
  logic          do_push;
  logic          do_pop;

  assign full    = cnt[AW];
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + AW'(1);
      end
      if (do_pop) begin
        rptr <= rptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt <= cnt - (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= din;
    end
  end

endmodule

// ----- rtl/imusbc_front.sv -----
module imusbc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  imusbc_pkg::in_t   sample,
  input  imusbc_pkg::thr_t  thr,
  output logic              mid_push,
  input  logic              mid_full,
  output imusbc_pkg::cls_t  mid_data
);

  logic            s1_valid;
  imusbc_pkg::in_t s1_smp;
  logic            s1_gok;
  logic [30:0]     s1_sq [3];
  logic [15:0]     gmag [3];
  logic [15:0]     amag [3];
  logic [31:0]     prod [3];
  logic [31:0]     sq;
  logic            still;
  logic            load;

  // Stage one: gyro limit test and the three accel squares.
  always_comb begin
    gmag[0] = imusbc_pkg::abs16(sample.gyro_x);
    gmag[1] = imusbc_pkg::abs16(sample.gyro_y);
    gmag[2] = imusbc_pkg::abs16(sample.gyro_z);
    amag[0] = imusbc_pkg::abs16(sample.accel_x);
    amag[1] = imusbc_pkg::abs16(sample.accel_y);
    amag[2] = imusbc_pkg::abs16(sample.accel_z);
    for (int i = 0; i < 3; i++) begin
      prod[i] = amag[i] * amag[i];
    end
  end

  assign full     = s1_valid && mid_full;
  assign load     = push && !full;
  assign mid_push = s1_valid && !mid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (mid_push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_smp <= sample;
      s1_gok <= (gmag[0] <= thr.gyro_limit) && (gmag[1] <= thr.gyro_limit) &&
                (gmag[2] <= thr.gyro_limit);
      for (int i = 0; i < 3; i++) begin
        s1_sq[i] <= prod[i][30:0];
      end
    end
  end

  // Stage two: the squared magnitude against the band.
  always_comb begin
    sq    = 32'(s1_sq[0]) + 32'(s1_sq[1]) + 32'(s1_sq[2]);
    still = s1_gok && (sq >= thr.sq_low) && (sq <= thr.sq_high);
  end

  assign mid_data = '{smp: s1_smp, still: still};

endmodule

// ----- rtl/imusbc_div.sv -----
module imusbc_div #(
  parameter int CW    = 16,
  parameter int SUM_W = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [SUM_W-1:0]               dividend,
  input  logic [CW-1:0]                         divisor,
  output logic                                  done,
  output logic signed [imusbc_pkg::OFF_W-1:0]   quotient
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]              mag;
  logic [CW-1:0]                 rem;
  logic [CW-1:0]                 dvsr;
  logic                          neg;
  logic [STEP_W-1:0]             step;
  logic [CW:0]                   rem_sh;
  logic [CW:0]                   diff;
  logic                          fits;
  logic [imusbc_pkg::OFF_W-1:0]  qmag;

  // One quotient bit per cycle, restoring form, on the magnitude.
  always_comb begin
    rem_sh = {rem, mag[SUM_W-1]};
    diff   = rem_sh - {1'b0, dvsr};
    fits   = (rem_sh >= {1'b0, dvsr});
    qmag   = mag[imusbc_pkg::OFF_W-1:0];
  end

  assign quotient = neg ? (~qmag + 1'b1) : qmag;

  // Done pulses for one cycle right after the last quotient bit is shifted in.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= !start && (step == STEP_W'(1));
      if (start) begin
        step <= STEP_W'(SUM_W);
      end else if (step != '0) begin
        step <= step - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= dividend[SUM_W-1];
      mag  <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
      rem  <= '0;
      dvsr <= divisor;
    end else if (step != '0) begin
      rem <= fits ? diff[CW-1:0] : rem_sh[CW-1:0];
      mag <= {mag[SUM_W-2:0], fits};
    end
  end

endmodule

// ----- rtl/imusbc_back.sv -----
module imusbc_back #(
  parameter int CW    = 16,
  parameter int SUM_W = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [15:0]            total,
  input  logic                   mid_empty,
  output logic                   mid_pop,
  input  imusbc_pkg::cls_t       mid_data,
  input  logic                   out_full,
  output logic                   out_push,
  output imusbc_pkg::out_t       out_data,
  output imusbc_pkg::bk_stat_t   stat
);

  localparam int EW  = (CW > 16) ? CW : 16;
  localparam int OW  = imusbc_pkg::OFF_W;
  localparam int NAX = imusbc_pkg::AXES;

  typedef enum logic [2:0] {
    ST_RUN  = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } bk_state_t;

  bk_state_t               state;
  logic                    latched;
  logic [CW-1:0]           cnt;
  logic signed [SUM_W-1:0] sums [NAX];
  logic signed [OW-1:0]    off [NAX];
  logic [2:0]              idx;
  logic                    kick;
  logic [CW-1:0]           n;
  imusbc_pkg::in_t         cur;

  logic signed [15:0]      hax [NAX];
  logic signed [15:0]      sax [NAX];
  logic signed [SUM_W-1:0] sum_add [NAX];
  logic [CW-1:0]           cnt_inc;
  logic [CW-1:0]           target;
  logic [EW-1:0]           total_ext;
  logic                    take;
  logic                    active;
  logic                    complete;
  imusbc_pkg::in_t         src;
  logic                    div_done;
  logic signed [OW-1:0]    quo;

  imusbc_div #(.CW(CW), .SUM_W(SUM_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (kick),
    .dividend (sums[idx]),
    .divisor  (n),
    .done     (div_done),
    .quotient (quo)
  );

  // Target count: zero counts as one, and it never exceeds the counter.
  always_comb begin
    total_ext = EW'(total);
    if (total == '0) begin
      target = CW'(1);
    end else if (total_ext > EW'({CW{1'b1}})) begin
      target = {CW{1'b1}};
    end else begin
      target = total_ext[CW-1:0];
    end
  end

  always_comb begin
    hax[0] = mid_data.smp.gyro_x;
    hax[1] = mid_data.smp.gyro_y;
    hax[2] = mid_data.smp.gyro_z;
    hax[3] = mid_data.smp.accel_x;
    hax[4] = mid_data.smp.accel_y;
    hax[5] = mid_data.smp.accel_z;
    for (int i = 0; i < NAX; i++) begin
      sum_add[i] = sums[i] + SUM_W'(hax[i]);
    end
    cnt_inc  = cnt + CW'(1);
    complete = (cnt_inc >= target) && (cnt_inc != '0);
    active   = !latched && !mid_data.smp.armed;
    take     = (state == ST_RUN) && !mid_empty && !out_full;
  end

  assign mid_pop  = take;
  assign out_push = (take && !(active && mid_data.still && complete)) ||
                    ((state == ST_DONE) && !out_full);

  // Result: the sample minus the biases, wrapped to 16 bits.
  always_comb begin
    src    = (state == ST_DONE) ? cur : mid_data.smp;
    sax[0] = src.gyro_x;
    sax[1] = src.gyro_y;
    sax[2] = src.gyro_z;
    sax[3] = src.accel_x;
    sax[4] = src.accel_y;
    sax[5] = src.accel_z;
    out_data.gyro_x_corr  = sax[0] - off[0][15:0];
    out_data.gyro_y_corr  = sax[1] - off[1][15:0];
    out_data.gyro_z_corr  = sax[2] - off[2][15:0];
    out_data.accel_x_corr = sax[3] - off[3][15:0];
    out_data.accel_y_corr = sax[4] - off[4][15:0];
    out_data.accel_z_corr = sax[5] - off[5][15:0];
    out_data.calibrated   = latched || (state == ST_DONE);
  end

  assign stat = '{latched: latched, dividing: (state == ST_DIV)};

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_RUN;
      latched <= 1'b0;
      cnt     <= '0;
      kick    <= 1'b0;
      idx     <= '0;
      for (int i = 0; i < NAX; i++) begin
        sums[i] <= '0;
        off[i]  <= '0;
      end
    end else begin
      case (state)
        ST_RUN: begin
          if (take && active) begin
            if (!mid_data.still) begin
              cnt <= '0;
              for (int i = 0; i < NAX; i++) begin
                sums[i] <= '0;
              end
            end else begin
              cnt <= cnt_inc;
              for (int i = 0; i < NAX; i++) begin
                sums[i] <= sum_add[i];
              end
              if (complete) begin
                cur   <= mid_data.smp;
                n     <= cnt_inc;
                idx   <= '0;
                kick  <= 1'b1;
                state <= ST_DIV;
              end
            end
          end
        end
        ST_DIV: begin
          // The next axis starts right after the current one is captured.
          kick <= div_done && (idx != 3'(NAX - 1));
          if (div_done) begin
            if (idx == 3'(NAX - 1)) begin
              off[idx] <= quo - imusbc_pkg::ONE_G_LSB;
              state    <= ST_DONE;
            end else begin
              off[idx] <= quo;
              idx      <= idx + 3'd1;
            end
          end
        end
        ST_DONE: begin
          // The completing beat waits here until the result buffer has room.
          if (!out_full) begin
            latched <= 1'b1;
            cnt     <= '0;
            for (int i = 0; i < NAX; i++) begin
              sums[i] <= '0;
            end
            state <= ST_RUN;
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

endmodule

// ----- rtl/imu_still_bias_calibrator.sv -----
// IMU still-bias calibrator. Every beat pushed in is one raw six-axis sample with an armed
// flag, and exactly one beat comes out for it, in order: the sample minus the current gyro
// and accel biases, wrapped to 16 bits, plus a calibrated flag. Until the biases latch, the
// block watches for stillness on disarmed samples (each gyro axis within gyro_limit and
// ax^2+ay^2+az^2 inside [sq_low, sq_high]); a moving sample restarts the average, and
// after total consecutive still samples the biases become the truncated means, with one g
// taken off accel Z, and calibrated stays high from that beat on until reset.
// A two-stage front end (abs and squares, then the band compare) classifies samples into a
// four-beat queue, and the back end applies them at one beat per clock while the result
// buffer has room, so the block then sustains one sample per cycle; a result passes the
// stage-one register, the queue and the result buffer before it can be popped. The one
// exception is the sample that completes the average: the back end then runs one shared
// bit-serial divider over the six sums, axis by axis, so that beat is held back, longer if
// the result buffer is full, while the front end keeps filling its queue. The user must
// write configuration registers only while the block is idle; the block does not enforce this.
module imu_still_bias_calibrator #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  imusbc_pkg::in_t                 sample,
  output logic                            empty,
  input  logic                            pop,
  output imusbc_pkg::out_t                result,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [imusbc_pkg::CFG_W-1:0]    cfg_data
);

  // Sums of up to 2^COUNT_WIDTH-1 samples of 16 bits, signed.
  localparam int SUM_W = COUNT_WIDTH + 16;
  localparam int CLS_W = $bits(imusbc_pkg::cls_t);
  localparam int OUT_W = $bits(imusbc_pkg::out_t);

  // Configuration registers.
  logic [15:0] gyro_limit;
  logic [31:0] sq_low;
  logic [31:0] sq_high;
  logic [15:0] total;

  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_limit <= imusbc_pkg::GYRO_LIMIT_RST;
      sq_low     <= imusbc_pkg::SQ_LOW_RST;
      sq_high    <= imusbc_pkg::SQ_HIGH_RST;
      total      <= imusbc_pkg::TOTAL_RST;
    end else if (cfg_we) begin
      case (imusbc_pkg::reg_idx_t'(cfg_index))
        imusbc_pkg::REG_GYRO_LIMIT: gyro_limit <= cfg_data[15:0];
        imusbc_pkg::REG_SQ_LOW:     sq_low     <= cfg_data;
        imusbc_pkg::REG_SQ_HIGH:    sq_high    <= cfg_data;
        imusbc_pkg::REG_TOTAL:      total      <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  imusbc_pkg::thr_t     thr;
  logic                 mid_push;
  logic                 mid_full;
  imusbc_pkg::cls_t     mid_in;
  logic                 mid_pop;
  logic                 mid_empty;
  logic [CLS_W-1:0]     mid_out;
  logic                 out_push;
  logic                 out_full;
  imusbc_pkg::out_t     out_in;
  logic [OUT_W-1:0]     out_out;
  imusbc_pkg::bk_stat_t bk_stat;

  assign thr = '{gyro_limit: gyro_limit, sq_low: sq_low, sq_high: sq_high};

  // Front end: classifies each sample as still or moving.
  imusbc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .sample   (sample),
    .thr      (thr),
    .mid_push (mid_push),
    .mid_full (mid_full),
    .mid_data (mid_in)
  );

  // Queue of classified samples between the two halves.
  imusbc_fifo #(.W(CLS_W), .AW(2)) u_mid (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .din   (mid_in),
    .full  (mid_full),
    .pop   (mid_pop),
    .dout  (mid_out),
    .empty (mid_empty)
  );

  // Back end: running sums, bias division and correction.
  imusbc_back #(.CW(COUNT_WIDTH), .SUM_W(SUM_W)) u_back (
    .clk       (clk),
    .rst       (rst),
    .total     (total),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .mid_data  (imusbc_pkg::cls_t'(mid_out)),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_data  (out_in),
    .stat      (bk_stat)
  );

  // Two-beat result buffer, so a stalled consumer does not stop the back end at once.
  imusbc_fifo #(.W(OUT_W), .AW(1)) u_out (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .din   (out_in),
    .full  (out_full),
    .pop   (pop),
    .dout  (out_out),
    .empty (empty)
  );

  assign result = imusbc_pkg::out_t'(out_out);

  // Once the biases latch they hold until reset.
  a_latch_holds: assert property (@(posedge clk) disable iff (rst)
    bk_stat.latched |=> bk_stat.latched)
    else $error("calibrated flag dropped after latching");

  // No result leaves the back end while the divider runs.
  a_no_push_dividing: assert property (@(posedge clk) disable iff (rst)
    bk_stat.dividing |-> !out_push)
    else $error("result pushed during bias division");

  // The back end never overruns the result buffer.
  a_out_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_push |-> !out_full)
    else $error("result buffer overrun");

  // The front end never overruns the classified-sample queue.
  a_mid_no_overrun: assert property (@(posedge clk) disable iff (rst)
    mid_push |-> !mid_full)
    else $error("sample queue overrun");

endmodule
